// ----- hw/rtl/rhm_pkg.sv -----
// ----------------------------------------------------------------------------
// rhm_pkg: shared types and constants for the running histogram median block
// Item and result structs, controller states and the scan control/status
// bundles passed between the controller and the per-channel rank accumulator.
// ----------------------------------------------------------------------------
package rhm_pkg;

    localparam int PIX_W  = 8;
    localparam int RANK_W = 8;
    localparam int NUM_CH = 3;

    localparam logic [RANK_W-1:0] RANK_RESET = 8'd5;
    localparam logic [PIX_W-1:0]  RANK_MISS  = 8'd255;

    typedef struct packed {
        logic             clear_all;
        logic             remove_valid;
        logic [PIX_W-1:0] remove_red;
        logic [PIX_W-1:0] remove_green;
        logic [PIX_W-1:0] remove_blue;
        logic             add_valid;
        logic [PIX_W-1:0] add_red;
        logic [PIX_W-1:0] add_green;
        logic [PIX_W-1:0] add_blue;
        logic             emit_median;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] median_red;
        logic [PIX_W-1:0] median_green;
        logic [PIX_W-1:0] median_blue;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REM_RD,
        ST_REM_WR,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SCAN,
        ST_OUT
    } state_t;

    // Scan control from the controller to each rank accumulator
    typedef struct packed {
        logic             start;
        logic             step;
        logic [PIX_W-1:0] idx;
    } scan_ctl_t;

    // Scan status back from each rank accumulator
    typedef struct packed {
        logic             found;
        logic [PIX_W-1:0] value;
    } rank_stat_t;

endpackage

// ----- hw/rtl/rhm_ram.sv -----
// ----------------------------------------------------------------------------
// rhm_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module rhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/rhm_rank_acc.sv -----
// ----------------------------------------------------------------------------
// rhm_rank_acc: running-count rank accumulator for one color channel
// Sums bin counts in ascending bin order and latches the first bin index at
// which the running count reaches the rank; reports 255 if never reached.
// ----------------------------------------------------------------------------
module rhm_rank_acc import rhm_pkg::*; #(
    parameter int CNT_W = 8,
    parameter int SUM_W = 17
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  scan_ctl_t         ctl,
    input  logic [RANK_W-1:0] rank,
    input  logic [CNT_W-1:0]  count,
    output rank_stat_t        stat
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             found_reg;
    logic [PIX_W-1:0] value_reg;
    logic             hit;

    assign sum_next = sum_reg + SUM_W'(count);
    assign hit      = (sum_next >= SUM_W'(rank));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.start) begin
            found_reg <= 1'b0;
        end else if (ctl.step && !found_reg && hit) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            sum_reg   <= '0;
            value_reg <= RANK_MISS;
        end else if (ctl.step && !found_reg) begin
            sum_reg <= sum_next;
            if (hit) begin
                value_reg <= ctl.idx;
            end
        end
    end

    assign stat.found = found_reg;
    assign stat.value = value_reg;

endmodule

// ----- hw/rtl/running_histogram_median_top.sv -----
// ----------------------------------------------------------------------------
// running_histogram_median_top: sliding-window RGB rank filter
// Keeps one count histogram per color in synchronous RAM, applies clear,
// remove and add updates per item, and on request scans the bins to report
// the ranked value of each channel.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                        Direction  Carries
//  -------   ---------------------------  ---------  -----------------------
//  input     s_valid / s_ready / s_data   in         clear, remove, add, emit
//  result    m_valid / m_ready / m_data   out        red, green, blue ranks
//  config    cfg_valid / cfg_ready / cfg_data  in    median_rank
//
//  Steps: an item passes accept, remove read/write and add read/write.
//  A clear_all adds a clearing sweep over all BIN_COUNT bins, one bin a cycle.
//  An emit adds a scan of up to min(BIN_COUNT,256) bins through each
//  channel's single RAM read port, ending early once all three ranks are
//  found, then a load of the result register.
//  Reset: a clearing sweep over all bins runs first; s_ready stays low.
//  Stalls: a held result does not block accept; an emitting item waits in
//  the result stage, with s_ready low, until the held result leaves.
// ----------------------------------------------------------------------------
module running_histogram_median_top import rhm_pkg::*; #(
    parameter int BIN_COUNT  = 256,
    parameter int MAX_WINDOW = 225
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RANK_W-1:0] cfg_data
);

    localparam int ADDR_W    = $clog2(BIN_COUNT);
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
    // Pixel values stop at 255, so bins above that always stay empty
    localparam int SCAN_BINS = (BIN_COUNT < 256) ? BIN_COUNT : 256;
    localparam int SUM_W     = $clog2(SCAN_BINS * MAX_WINDOW + 1) + 1;

    localparam logic [ADDR_W-1:0] LAST_BIN  = ADDR_W'(BIN_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_SCAN = ADDR_W'(SCAN_BINS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_WINDOW);

    // Controller state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              dv_reg, dv_next;
    logic              issue_done_reg, issue_done_next;
    logic              clr_item_reg, clr_item_next;
    logic              m_valid_reg, m_valid_next;
    logic              load_out;
    in_item_t          item_reg;
    out_item_t         m_data_reg;
    logic [RANK_W-1:0] rank_reg;

    scan_ctl_t         scan_ctl;
    rank_stat_t        stat [NUM_CH];
    logic              all_found;

    logic [PIX_W-1:0]  rem_pix [NUM_CH];
    logic [PIX_W-1:0]  add_pix [NUM_CH];

    assign rem_pix[0] = item_reg.remove_red;
    assign rem_pix[1] = item_reg.remove_green;
    assign rem_pix[2] = item_reg.remove_blue;
    assign add_pix[0] = item_reg.add_red;
    assign add_pix[1] = item_reg.add_green;
    assign add_pix[2] = item_reg.add_blue;

    assign all_found = stat[0].found && stat[1].found && stat[2].found;

    // ------------------------------------------------------------------
    // Configuration: always ready; the user, not the block, sees it written only while the block is idle
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg <= RANK_RESET;
        end else if (cfg_valid) begin
            rank_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        issue_done_next = issue_done_reg;
        clr_item_next   = clr_item_reg;
        idx_next        = ptr_reg;
        load_out        = 1'b0;
        scan_ctl.start  = 1'b0;
        scan_ctl.step   = dv_reg;
        scan_ctl.idx    = PIX_W'(idx_reg);

        unique case (state_reg)
            ST_CLEAR: begin
                // Sweep zeroes through every bin, one address a cycle;
                // an item's clear goes on to that item's updates
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_BIN) begin
                    ptr_next   = '0;
                    state_next = clr_item_reg ? ST_REM_RD : ST_IDLE;
                end
            end
            ST_IDLE: begin
                ptr_next = '0;
                if (s_valid) begin
                    clr_item_next = s_data.clear_all;
                    state_next    = s_data.clear_all ? ST_CLEAR : ST_REM_RD;
                end
            end
            ST_REM_RD: begin
                state_next = ST_REM_WR;
            end
            ST_REM_WR: begin
                state_next = ST_ADD_RD;
            end
            ST_ADD_RD: begin
                state_next = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                ptr_next        = '0;
                issue_done_next = 1'b0;
                if (item_reg.emit_median) begin
                    scan_ctl.start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // Issue one bin read a cycle; its data returns in the next cycle
                if (!issue_done_reg) begin
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_reg == LAST_SCAN) begin
                        issue_done_next = 1'b1;
                    end
                end
                if (all_found || (dv_reg && idx_reg == LAST_SCAN)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        dv_next = (state_reg == ST_SCAN) && !issue_done_reg && (state_next == ST_SCAN);

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            ptr_reg        <= '0;
            dv_reg         <= 1'b0;
            issue_done_reg <= 1'b0;
            clr_item_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            dv_reg         <= dv_next;
            issue_done_reg <= issue_done_next;
            clr_item_reg   <= clr_item_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers: item latched on transfer, result on load
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (load_out) begin
            m_data_reg.median_red   <= stat[0].value;
            m_data_reg.median_green <= stat[1].value;
            m_data_reg.median_blue  <= stat[2].value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Per-channel histogram RAM and rank accumulator
    // ------------------------------------------------------------------
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_chan
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
        logic              wr_en;
        logic [CNT_W-1:0]  rd_count;
        logic [ADDR_W-1:0] rem_addr;
        logic [ADDR_W-1:0] add_addr;
        logic              rem_ok;
        logic              add_ok;

        assign rem_addr = ADDR_W'(rem_pix[ch]);
        assign add_addr = ADDR_W'(add_pix[ch]);
        // Drop values that fall beyond the last bin
        assign rem_ok   = (int'(rem_pix[ch]) < BIN_COUNT);
        assign add_ok   = (int'(add_pix[ch]) < BIN_COUNT);

        always_comb begin
            rd_addr = ptr_reg;
            wr_addr = ptr_reg;
            wr_data = '0;
            wr_en   = 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    wr_en = 1'b1;
                end
                ST_REM_RD: begin
                    rd_addr = rem_addr;
                end
                ST_REM_WR: begin
                    // Ignore a removal from an empty bin
                    wr_addr = rem_addr;
                    wr_data = rd_count - 1'b1;
                    wr_en   = item_reg.remove_valid && rem_ok && (rd_count != '0);
                end
                ST_ADD_RD: begin
                    rd_addr = add_addr;
                end
                ST_ADD_WR: begin
                    // Saturate at the window maximum
                    wr_addr = add_addr;
                    wr_data = rd_count + 1'b1;
                    wr_en   = item_reg.add_valid && add_ok && (rd_count < CNT_MAX);
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end

        rhm_ram #(
            .WIDTH (CNT_W),
            .DEPTH (BIN_COUNT)
        ) u_bins (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_addr),
            .rd_data (rd_count)
        );

        rhm_rank_acc #(
            .CNT_W (CNT_W),
            .SUM_W (SUM_W)
        ) u_acc (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (scan_ctl),
            .rank    (rank_reg),
            .count   (rd_count),
            .stat    (stat[ch])
        );
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_clear_goes_remove: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.clear_all |=> state_reg == ST_REM_RD)
        else $error("item without clear did not start the remove read");

    a_out_needs_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> item_reg.emit_median)
        else $error("result stage reached for an item without emit");

    a_data_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg |-> state_reg == ST_SCAN)
        else $error("scan data flagged outside the scan");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result raised without passing the result stage");

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for running_histogram_median_top
// Feeds clear/remove/add/emit items over the input channel. A local copy of
// the three color histograms and the rank register predicts each ranked
// result, and every result transfer is compared field by field against the
// oldest prediction. Covers fixed corner items, rank extremes, bin
// saturation, sliding windows of several sizes and random noise items, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import rhm_pkg::*;

    localparam int     BINS     = 256;
    localparam int     WIN_MAX  = 225;
    localparam int     IDLE_PCT = 18;
    // An item with no result may still be busy after the last result:
    // a full clearing sweep plus the read/write cycles of its updates.
    localparam int     SETTLE   = BINS + 64;
    localparam longint LIMIT    = 64'd60_000_000;

    // Channel indexes into the histogram copy
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Pixel value spreads: narrow spreads force ties in the bins
    localparam int PIX_FULL   = 0;
    localparam int PIX_LOW    = 1;
    localparam int PIX_HIGH   = 2;
    localparam int PIX_NARROW = 3;

    typedef logic [NUM_CH*PIX_W-1:0] rgb_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RANK_W-1:0] cfg_data  = '0;

    // Histogram copy, rank copy and the ranked results still owed by the block
    int unsigned       hist [NUM_CH][BINS];
    logic [RANK_W-1:0] rank_cfg = RANK_RESET;
    out_item_t         pending_medians [$];
    int                failures = 0;
    bit                steady   = 1'b0;

    running_histogram_median_top #(
        .BIN_COUNT  (BINS),
        .MAX_WINDOW (WIN_MAX)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Smallest bin whose running count reaches the rank; miss value otherwise.
    // A rank of zero is met at bin 0 already.
    function automatic logic [PIX_W-1:0] ranked_value(input int c);
        int unsigned running;
        running = 0;
        for (int k = 0; k < BINS; k++) begin
            running += hist[c][k];
            if (running >= rank_cfg)
                return k[PIX_W-1:0];
        end
        return RANK_MISS;
    endfunction

    // Apply one accepted item: clear, then remove, then add, then rank on request
    function automatic void update_histograms(input in_item_t it);
        logic [PIX_W-1:0] leave_px [NUM_CH];
        logic [PIX_W-1:0] enter_px [NUM_CH];
        out_item_t        res;
        leave_px = '{it.remove_red, it.remove_green, it.remove_blue};
        enter_px = '{it.add_red, it.add_green, it.add_blue};
        if (it.clear_all)
            foreach (hist[c, k]) hist[c][k] = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            // removal from an empty bin is dropped
            if (it.remove_valid && hist[c][leave_px[c]] > 0)
                hist[c][leave_px[c]]--;
            // counts saturate at the window maximum
            if (it.add_valid && hist[c][enter_px[c]] < WIN_MAX)
                hist[c][enter_px[c]]++;
        end
        if (it.emit_median) begin
            res.median_red   = ranked_value(CH_RED);
            res.median_green = ranked_value(CH_GREEN);
            res.median_blue  = ranked_value(CH_BLUE);
            pending_medians.push_back(res);
        end
    endfunction

    function automatic in_item_t make_item(input bit clr, input bit rem_en, input rgb_t leave,
                                           input bit add_en, input rgb_t enter, input bit emit);
        in_item_t it;
        it.clear_all    = clr;
        it.remove_valid = rem_en;
        {it.remove_red, it.remove_green, it.remove_blue} = leave;
        it.add_valid    = add_en;
        {it.add_red, it.add_green, it.add_blue} = enter;
        it.emit_median  = emit;
        return it;
    endfunction

    function automatic rgb_t random_rgb(input int spread);
        rgb_t px;
        for (int c = 0; c < NUM_CH; c++) begin
            case (spread)
                PIX_LOW:    px[c*PIX_W +: PIX_W] = PIX_W'($urandom_range(7, 0));
                PIX_HIGH:   px[c*PIX_W +: PIX_W] = PIX_W'($urandom_range(255, 248));
                PIX_NARROW: px[c*PIX_W +: PIX_W] = PIX_W'($urandom_range(140, 120));
                default:    px[c*PIX_W +: PIX_W] = PIX_W'($urandom_range(255, 0));
            endcase
        end
        return px;
    endfunction

    // Any field pattern; clears kept rare so the histograms fill up
    function automatic in_item_t noise_item();
        logic [63:0] raw;
        in_item_t    it;
        raw = {$urandom, $urandom};
        it  = raw[$bits(in_item_t)-1:0];
        it.clear_all = ($urandom_range(99) < 5);
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                        input logic [PIX_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Present one item, hold it until the transfer, then predict. Valid is
    // left high so back-to-back items need no extra edge.
    task automatic send_item(input in_item_t it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        update_histograms(it);
    endtask

    // Drop valid and wait for every owed result; optionally let a result-free
    // item finish its sweep too.
    task automatic drain_results(input bit settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_medians.size() != 0) @(posedge aclk);
        if (settle)
            repeat (SETTLE) @(posedge aclk);
    endtask

    // Rank writes happen only with the block idle
    task automatic write_rank(input logic [RANK_W-1:0] rank);
        drain_results(1'b1);
        cfg_valid <= 1'b1;
        cfg_data  <= rank;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        rank_cfg = rank;
    endtask

    task automatic test_directed();
        // empty histograms at the reset rank: rank never reached
        send_item(make_item(0, 0, '0, 0, '0, 1));
        // removal from an empty bin
        send_item(make_item(0, 1, 24'h070707, 0, '0, 1));
        send_item(make_item(0, 0, '0, 1, 24'h00FF55, 0));
        send_item(make_item(0, 0, '0, 1, 24'hFF00AA, 0));
        send_item(make_item(0, 0, '0, 1, 24'h0FF000, 0));
        send_item(make_item(0, 0, '0, 1, 24'h8001FF, 1));
        // fifth pixel reaches the reset rank
        send_item(make_item(0, 0, '0, 1, 24'h01807F, 1));
        send_item(make_item(0, 0, '0, 1, 24'h000000, 1));
        // remove and add together: remove first
        send_item(make_item(0, 1, 24'hFF00AA, 1, 24'hC8C8C8, 1));
        send_item(make_item(0, 1, 24'h123456, 1, 24'h123456, 1));
        // disabled remove/add fields must be ignored, no result
        send_item(make_item(0, 0, 24'hFFFFFF, 0, 24'hFFFFFF, 0));
        send_item(make_item(0, 0, '0, 0, '0, 1));
        // clear before the updates
        send_item(make_item(1, 0, '0, 1, 24'h090909, 1));
        send_item(make_item(1, 1, 24'h090909, 0, '0, 1));
        send_item(make_item(1, 1, 24'hFFFFFF, 1, 24'hFFFFFF, 1));
        send_item(make_item(1, 0, '0, 0, '0, 0));
    endtask

    task automatic test_rank_extremes();
        // rank zero stops at the first bin
        write_rank(8'd0);
        send_item(make_item(0, 0, '0, 0, '0, 1));
        send_item(make_item(0, 0, '0, 1, 24'h804020, 1));
        write_rank(8'd1);
        send_item(make_item(0, 0, '0, 0, '0, 1));
        send_item(make_item(0, 0, '0, 1, 24'hFF007F, 1));
        write_rank(8'd2);
        send_item(make_item(0, 0, '0, 0, '0, 1));
        write_rank(8'hFF);
        send_item(make_item(0, 0, '0, 0, '0, 1));
        send_item(make_item(1, 0, '0, 0, '0, 1));
    endtask

    // Push one bin past the window maximum, then step back below the rank
    task automatic test_saturation();
        rgb_t px;
        write_rank(WIN_MAX[RANK_W-1:0]);
        px = random_rgb(PIX_FULL);
        send_item(make_item(1, 0, '0, 1, px, 0));
        repeat (WIN_MAX + 7)
            send_item(make_item(0, 0, '0, 1, px, $urandom_range(99) < 8));
        send_item(make_item(0, 0, '0, 0, '0, 1));
        send_item(make_item(0, 1, px, 0, '0, 1));
        send_item(make_item(0, 0, '0, 1, px, 1));
    endtask

    // Window: clear and fill, then slide with remove-oldest/add-new or a noise item.
    // Hold the sender halfway until every median is back.
    task automatic run_window(input int size, input int slides, input int spread);
        rgb_t win [$];
        rgb_t px;
        if ($urandom_range(3) == 0)
            write_rank(RANK_W'($urandom_range(255, 1)));
        else
            write_rank(RANK_W'(size / 2 + 1));
        px = random_rgb(spread);
        win.push_back(px);
        send_item(make_item(1, 0, '0, 1, px, 0));
        while (win.size() < size) begin
            px = random_rgb(spread);
            win.push_back(px);
            send_item(make_item(0, 0, '0, 1, px, $urandom_range(99) < 5));
        end
        for (int s = 0; s < slides; s++) begin
            if (s == slides / 2)
                drain_results(1'b0);
            if ($urandom_range(99) < 10) begin
                send_item(noise_item());
            end else begin
                px = random_rgb(spread);
                send_item(make_item(0, 1, win.pop_front(), 1, px, $urandom_range(99) < 80));
                win.push_back(px);
            end
        end
    endtask

    task automatic test_sliding();
        run_window(9, 60, PIX_FULL);
        // no idling on either side for a whole window
        steady = 1'b1;
        run_window(25, 60, PIX_NARROW);
        steady = 1'b0;
        run_window(49, 40, PIX_LOW);
        run_window(WIN_MAX, 30, PIX_HIGH);
    endtask

    task automatic test_noise();
        for (int n = 0; n < 60; n++) begin
            if (n % 20 == 0)
                write_rank(RANK_W'($urandom_range(255, 0)));
            send_item(noise_item());
        end
    endtask

    // Randomly stall the result channel
    always @(posedge aclk)
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // Compare each result transfer against the oldest prediction
    always @(posedge aclk) begin : score_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                $error("unexpected median result: %h", m_data);
                failures++;
            end else begin
                want = pending_medians.pop_front();
                check_field("median_red", want.median_red, m_data.median_red);
                check_field("median_green", want.median_green, m_data.median_green);
                check_field("median_blue", want.median_blue, m_data.median_blue);
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_rank_extremes();
        test_saturation();
        test_sliding();
        test_noise();
        drain_results(1'b1);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #(LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/rhm_pkg.sv
hw/rtl/rhm_ram.sv
hw/rtl/rhm_rank_acc.sv
hw/rtl/running_histogram_median_top.sv
tb/sv/testbench.sv
